// ----- design/sfs_pkg.sv -----
// Shared constants, types and command/status bundles for the serial frame synchronizer.
package sfs_pkg;

  localparam int MAX_PACKET = 64;
  localparam int SIGN_BYTES = 4;

  localparam int AW       = $clog2(MAX_PACKET);
  localparam int RAM_DEPTH = 1 << AW;
  localparam int CNT_W    = $clog2(MAX_PACKET + 1);
  localparam int HEAD_W   = 8 * SIGN_BYTES;
  localparam int CMP_W    = (HEAD_W > 32) ? HEAD_W : 32;

  localparam logic [6:0]  PACKET_SIZE_RST   = 7'd64;
  localparam logic [31:0] SIGNATURE_RST     = 32'd0;
  localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd100;

  typedef enum logic [1:0] {
    REG_PACKET_SIZE   = 2'd0,
    REG_SIGNATURE     = 2'd1,
    REG_TIMEOUT_LIMIT = 2'd2
  } sfs_reg_e;

  typedef enum logic [0:0] {
    KIND_BYTE = 1'b0,
    KIND_IDLE = 1'b1
  } sfs_kind_e;

  typedef struct packed {
    logic start;
    logic rd_issue;
    logic hdr_cap;
    logic pkt_accept;
    logic drop;
    logic load_status;
    logic load_pkt;
  } sfs_cmd_t;

  typedef struct packed {
    logic go_hdr;
    logic hdr_done;
    logic match;
    logic pkt_last;
    logic out_free;
  } sfs_stat_t;

endpackage

// ----- design/sfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sfs_ctrl.sv -----
// Sequencing state machine for the serial frame synchronizer.
module sfs_ctrl import sfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sfs_stat_t stat_i,
  output sfs_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STAT = 7'b0000010,
    S_HRD  = 7'b0000100,
    S_HCAP = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_PRD  = 7'b0100000,
    S_PCAP = 7'b1000000
  } sfs_state_e;

  sfs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.go_hdr ? S_HRD : S_STAT;
        end
      end
      S_STAT: begin
        if (stat_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_HRD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_HCAP;
      end
      S_HCAP: begin
        cmd_o.hdr_cap = 1'b1;
        state_d       = stat_i.hdr_done ? S_CMP : S_HRD;
      end
      S_CMP: begin
        if (stat_i.match) begin
          cmd_o.pkt_accept = 1'b1;
          state_d          = S_PRD;
        end else begin
          cmd_o.drop = 1'b1;
          state_d    = S_STAT;
        end
      end
      S_PRD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_PCAP;
      end
      S_PCAP: begin
        if (stat_i.out_free) begin
          cmd_o.load_pkt = 1'b1;
          state_d        = stat_i.pkt_last ? S_IDLE : S_PRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- design/sfs_datapath.sv -----
// Window storage, header compare, counters, configuration and result register.
module sfs_datapath import sfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_kind_i,
  input  logic [7:0]  in_data_byte_i,
  input  logic        out_stall_i,
  input  sfs_cmd_t    cmd_i,
  output sfs_stat_t   stat_o,
  output logic        out_valid_o,
  output logic        out_packet_valid_o,
  output logic [7:0]  out_packet_byte_o,
  output logic        out_last_o,
  output logic        out_skipped_o,
  output logic        out_no_reply_o,
  output logic [31:0] out_received_count_o,
  output logic [31:0] out_skipped_count_o,
  output logic [31:0] out_packet_count_o
);

  logic [6:0]        packet_size_q;
  logic [31:0]       signature_q;
  logic [15:0]       timeout_limit_q;
  logic [CNT_W-1:0]  fill_q;
  logic [AW-1:0]     base_q;
  logic [CNT_W-1:0]  rd_cnt_q;
  logic [15:0]       idle_q;
  logic              flag_q;
  logic              skip_q;
  logic [31:0]       rc_q, sc_q, pc_q;
  logic [HEAD_W-1:0] head_q;

  logic              out_valid_q;
  logic              out_pv_q, out_last_q, out_skip_q, out_nr_q;
  logic [7:0]        out_byte_q;
  logic [31:0]       out_rc_q, out_sc_q, out_pc_q;

  logic [CNT_W-1:0]  eff_size;
  logic [CNT_W-1:0]  fill_inc;
  logic              tmo;
  logic [31:0]       rc_b, sc_b, pc_b;
  logic [15:0]       idle_b;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_rdata;
  logic              out_free;

  always_comb begin
    if (32'(packet_size_q) < SIGN_BYTES) begin
      eff_size = CNT_W'(SIGN_BYTES);
    end else if (32'(packet_size_q) > MAX_PACKET) begin
      eff_size = CNT_W'(MAX_PACKET);
    end else begin
      eff_size = CNT_W'(packet_size_q);
    end
  end

  assign fill_inc = fill_q + CNT_W'(1);
  assign tmo      = (idle_q == timeout_limit_q) && !flag_q;
  assign rc_b     = tmo ? 32'd0 : rc_q;
  assign sc_b     = tmo ? 32'd0 : sc_q;
  assign pc_b     = tmo ? 32'd0 : pc_q;
  assign idle_b   = tmo ? 16'd0 : idle_q;

  assign ram_we    = cmd_i.start && (in_kind_i == KIND_BYTE);
  assign ram_waddr = base_q + fill_q[AW-1:0];
  assign ram_re    = cmd_i.rd_issue;
  assign ram_raddr = base_q + rd_cnt_q[AW-1:0];

  sfs_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.go_hdr   = (in_kind_i == KIND_BYTE) && (fill_inc >= eff_size);
  assign stat_o.hdr_done = (rd_cnt_q == CNT_W'(SIGN_BYTES));
  assign stat_o.match    = (CMP_W'(head_q) == CMP_W'(signature_q));
  assign stat_o.pkt_last = (rd_cnt_q == eff_size);
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_size_q   <= PACKET_SIZE_RST;
      signature_q     <= SIGNATURE_RST;
      timeout_limit_q <= TIMEOUT_LIMIT_RST;
      fill_q          <= '0;
      base_q          <= '0;
      rd_cnt_q        <= '0;
      idle_q          <= '0;
      flag_q          <= 1'b0;
      skip_q          <= 1'b0;
      rc_q            <= '0;
      sc_q            <= '0;
      pc_q            <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PACKET_SIZE: begin
            packet_size_q <= cfg_data_i[6:0];
            fill_q        <= '0;
          end
          REG_SIGNATURE: begin
            signature_q <= cfg_data_i;
          end
          REG_TIMEOUT_LIMIT: begin
            timeout_limit_q <= cfg_data_i[15:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.start) begin
        skip_q   <= 1'b0;
        rd_cnt_q <= '0;
        sc_q     <= sc_b;
        pc_q     <= pc_b;
        if (in_kind_i == KIND_IDLE) begin
          idle_q <= (idle_b == 16'hFFFF) ? idle_b : idle_b + 16'd1;
          flag_q <= flag_q | tmo;
          rc_q   <= rc_b;
        end else begin
          idle_q <= '0;
          flag_q <= 1'b0;
          rc_q   <= (rc_b == 32'hFFFF_FFFF) ? rc_b : rc_b + 32'd1;
          fill_q <= fill_inc;
        end
      end
      if (cmd_i.rd_issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
      if (cmd_i.pkt_accept) begin
        pc_q     <= (pc_q == 32'hFFFF_FFFF) ? pc_q : pc_q + 32'd1;
        fill_q   <= '0;
        rd_cnt_q <= '0;
      end
      if (cmd_i.drop) begin
        base_q <= base_q + AW'(1);
        fill_q <= fill_q - CNT_W'(1);
        sc_q   <= (sc_q == 32'hFFFF_FFFF) ? sc_q : sc_q + 32'd1;
        skip_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_cap) begin
      if (HEAD_W > 8) begin
        head_q <= {ram_rdata, head_q[HEAD_W-1:8]};
      end else begin
        head_q <= HEAD_W'(ram_rdata);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_status || cmd_i.load_pkt) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status || cmd_i.load_pkt) begin
      out_pv_q   <= cmd_i.load_pkt;
      out_byte_q <= cmd_i.load_pkt ? ram_rdata : 8'd0;
      out_last_q <= cmd_i.load_status || stat_o.pkt_last;
      out_skip_q <= cmd_i.load_status && skip_q;
      out_nr_q   <= flag_q;
      out_rc_q   <= rc_q;
      out_sc_q   <= sc_q;
      out_pc_q   <= pc_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_packet_valid_o   = out_pv_q;
  assign out_packet_byte_o    = out_byte_q;
  assign out_last_o           = out_last_q;
  assign out_skipped_o        = out_skip_q;
  assign out_no_reply_o       = out_nr_q;
  assign out_received_count_o = out_rc_q;
  assign out_skipped_count_o  = out_sc_q;
  assign out_packet_count_o   = out_pc_q;

endmodule

// ----- design/serial_frame_sync_top.sv -----
// Top level of the serial frame synchronizer: controller, datapath and port wiring.
// A byte that does not fill the window or an idle tick goes through the status state to its status result.
// A byte that fills the window adds a read and capture per signature byte for the header, then a compare.
// A matched packet then streams out one byte per read and capture step through the single window memory read port.
// A new request is taken while the previous final result still waits in the output register.
// Reset clears configuration to its defaults and all counters; the window memory is not cleared.
module serial_frame_sync_top import sfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_packet_valid_o,
  output logic [7:0]  out_packet_byte_o,
  output logic        out_last_o,
  output logic        out_skipped_o,
  output logic        out_no_reply_o,
  output logic [31:0] out_received_count_o,
  output logic [31:0] out_skipped_count_o,
  output logic [31:0] out_packet_count_o
);

  sfs_cmd_t  cmd;
  sfs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfs_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_kind_i            (in_kind_i),
    .in_data_byte_i       (in_data_byte_i),
    .out_stall_i          (out_stall_i),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .out_valid_o          (out_valid_o),
    .out_packet_valid_o   (out_packet_valid_o),
    .out_packet_byte_o    (out_packet_byte_o),
    .out_last_o           (out_last_o),
    .out_skipped_o        (out_skipped_o),
    .out_no_reply_o       (out_no_reply_o),
    .out_received_count_o (out_received_count_o),
    .out_skipped_count_o  (out_skipped_count_o),
    .out_packet_count_o   (out_packet_count_o)
  );

endmodule

// ----- design/sfs_checker.sv -----
// Port-level assertions for the serial frame synchronizer and their bind to the top level.
module sfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_packet_valid_o,
  input logic        out_last_o,
  input logic        out_skipped_o,
  input logic        out_no_reply_o,
  input logic [31:0] out_received_count_o,
  input logic [31:0] out_packet_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result request was dropped.");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_packet_valid_o |-> out_last_o)
    else $error("Status result is not marked last.");

  a_skip_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_skipped_o |-> !out_packet_valid_o)
    else $error("Skip flag set on a packet byte.");

  a_noreply_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_no_reply_o |-> (out_received_count_o == 32'd0) &&
                                      (out_packet_count_o == 32'd0))
    else $error("Counters not cleared while no-reply is set.");

endmodule

bind serial_frame_sync_top sfs_checker u_sfs_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .out_packet_valid_o   (out_packet_valid_o),
  .out_last_o           (out_last_o),
  .out_skipped_o        (out_skipped_o),
  .out_no_reply_o       (out_no_reply_o),
  .out_received_count_o (out_received_count_o),
  .out_packet_count_o   (out_packet_count_o)
);
